### hdl/touch_sample_filter_top_macros.svh
// touch_sample_filter_top_macros.svh: assertion macros for the touch sample filter
// used by the checker file; needs nothing else
`ifndef TOUCH_SAMPLE_FILTER_TOP_MACROS_SVH
`define TOUCH_SAMPLE_FILTER_TOP_MACROS_SVH

// same-cycle implication, off while in reset
`define TSF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define TSF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also runs through reset
`define TSF_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/tsf_pkg.sv
// tsf_pkg: widths, reset values, register indexes and shared structs
// of the touch sample filter; depends on nothing
package tsf_pkg;

  localparam int TSF_SAMPLES = 4;
  localparam int ADC_W       = 12;
  localparam int TICK_W      = 32;
  localparam int GAP_W       = 16;
  localparam int MARGIN_W    = 11;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [ADC_W-1:0]    ADC_MAX          = 12'hFFF;
  localparam logic [GAP_W-1:0]    MIN_GAP_RESET    = 16'd20;
  localparam logic [ADC_W-1:0]    SPREAD_RESET     = 12'd50;
  localparam logic [ADC_W-1:0]    JUMP_RESET       = 12'd50;
  localparam logic [MARGIN_W-1:0] EDGE_MARGIN_RESET = 11'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_GAP = 8'd0,
    CFG_SPREAD  = 8'd1,
    CFG_JUMP    = 8'd2,
    CFG_MARGIN  = 8'd3
  } tsf_cfg_idx_t;

  typedef struct packed {
    logic [GAP_W-1:0]    min_gap;
    logic [ADC_W-1:0]    spread_limit;
    logic [ADC_W-1:0]    jump_limit;
    logic [MARGIN_W-1:0] edge_margin;
  } tsf_cfg_t;

  typedef struct packed {
    logic             bad;
    logic [ADC_W-1:0] value;
  } tsf_axis_t;

  typedef struct packed {
    logic             emit;
    logic             contact;
    logic [ADC_W-1:0] touch_x;
    logic [ADC_W-1:0] touch_y;
  } tsf_result_t;

endpackage

### hdl/tsf_channels.sv
// tsf_channels: valid/ready channel interfaces for sample items, results
// and register writes; depends on tsf_pkg
interface tsf_in_if import tsf_pkg::*; #(
  parameter int SAMPLES = TSF_SAMPLES
) ();
  logic                       valid;
  logic                       ready;
  logic [TICK_W-1:0]          now_ticks;
  logic [SAMPLES*ADC_W-1:0]   x_sample;
  logic [SAMPLES*ADC_W-1:0]   y_sample;

  modport source (output valid, output now_ticks, output x_sample, output y_sample,
                  input ready);
  modport sink   (input valid, input now_ticks, input x_sample, input y_sample,
                  output ready);
endinterface

interface tsf_out_if import tsf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             contact;
  logic [ADC_W-1:0] touch_x;
  logic [ADC_W-1:0] touch_y;

  modport source (output valid, output contact, output touch_x, output touch_y,
                  input ready);
  modport sink   (input valid, input contact, input touch_x, input touch_y,
                  output ready);
endinterface

interface tsf_cfg_if import tsf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/tsf_lane.sv
// tsf_lane: one axis lane, picks the two middle readings by rank and
// averages them and flags a wide spread; depends on tsf_pkg
module tsf_lane import tsf_pkg::*; #(
  parameter int SAMPLES = TSF_SAMPLES
) (
  input  logic [SAMPLES*ADC_W-1:0] samples,
  input  logic [ADC_W-1:0]         spread_limit,
  output tsf_axis_t                axis
);

  localparam int RANK_W = $clog2(SAMPLES);
  localparam logic [RANK_W-1:0] HI_RANK = RANK_W'(SAMPLES / 2 - 1);
  localparam logic [RANK_W-1:0] LO_RANK = RANK_W'(SAMPLES / 2);

  logic [ADC_W-1:0]  v    [SAMPLES];
  logic [RANK_W-1:0] rank [SAMPLES];
  logic [ADC_W-1:0]  hi;
  logic [ADC_W-1:0]  lo;
  logic [ADC_W-1:0]  spread;
  logic [ADC_W:0]    sum;

  // descending position, ties broken by reading order
  always_comb begin
    for (int i = 0; i < SAMPLES; i++) begin
      v[i] = samples[i*ADC_W +: ADC_W];
    end
    for (int i = 0; i < SAMPLES; i++) begin
      rank[i] = '0;
      for (int j = 0; j < SAMPLES; j++) begin
        if (j != i) begin
          rank[i] = rank[i] + RANK_W'((samples[j*ADC_W +: ADC_W] > v[i]) ||
                    ((samples[j*ADC_W +: ADC_W] == v[i]) && (j < i)));
        end
      end
    end
  end

  always_comb begin
    hi = '0;
    lo = '0;
    for (int i = 0; i < SAMPLES; i++) begin
      if (rank[i] == HI_RANK) begin
        hi = v[i];
      end
      if (rank[i] == LO_RANK) begin
        lo = v[i];
      end
    end
    spread     = hi - lo;
    sum        = {1'b0, hi} + {1'b0, lo};
    axis.bad   = spread > spread_limit;
    axis.value = sum[ADC_W:1];
  end

endmodule

### hdl/tsf_merge.sv
// tsf_merge: combines both lanes with the stored previous sample, applies
// gap, edge and jump tests and holds the filter state; depends on tsf_pkg
module tsf_merge import tsf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [TICK_W-1:0] now_ticks,
  input  tsf_axis_t         x_axis,
  input  tsf_axis_t         y_axis,
  input  tsf_cfg_t          cfg,
  output tsf_result_t       res
);

  logic [ADC_W-1:0]  prev_x_r, prev_x_nxt;
  logic [ADC_W-1:0]  prev_y_r, prev_y_nxt;
  logic [TICK_W-1:0] last_down_r, last_down_nxt;

  logic [TICK_W-1:0] gap;
  logic              gap_ok;
  logic              bad;
  logic [ADC_W-1:0]  nx, ny;
  logic [ADC_W-1:0]  margin, hi_edge;
  logic              at_edge;
  logic [ADC_W-1:0]  dx, dy;
  logic              jumped;
  logic [ADC_W:0]    sum_x, sum_y;

  always_comb begin
    gap     = now_ticks - last_down_r;
    gap_ok  = gap > TICK_W'(cfg.min_gap);
    bad     = x_axis.bad || y_axis.bad;
    nx      = bad ? '0 : x_axis.value;
    ny      = bad ? '0 : y_axis.value;
    margin  = ADC_W'(cfg.edge_margin);
    hi_edge = ADC_MAX - margin;
    at_edge = (nx <= margin) || (ny <= margin) || (nx >= hi_edge) || (ny >= hi_edge);
    dx      = (prev_x_r > nx) ? prev_x_r - nx : nx - prev_x_r;
    dy      = (prev_y_r > ny) ? prev_y_r - ny : ny - prev_y_r;
    jumped  = (dx > cfg.jump_limit) || (dy > cfg.jump_limit);
    sum_x   = {1'b0, prev_x_r} + {1'b0, nx};
    sum_y   = {1'b0, prev_y_r} + {1'b0, ny};

    res.emit    = gap_ok && (at_edge || !jumped);
    res.contact = !at_edge;
    res.touch_x = at_edge ? '0 : sum_x[ADC_W:1];
    res.touch_y = at_edge ? '0 : sum_y[ADC_W:1];
  end

  always_comb begin
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    last_down_nxt = last_down_r;
    if (fire && gap_ok) begin
      prev_x_nxt = nx;
      prev_y_nxt = ny;
      if (!at_edge && !jumped) begin
        last_down_nxt = now_ticks;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      last_down_r <= '0;
    end else begin
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      last_down_r <= last_down_nxt;
    end
  end

endmodule

### hdl/touch_sample_filter_top.sv
// touch_sample_filter_top: resistive touch sample filter, top level
// depends on tsf_pkg, tsf_channels, tsf_lane and tsf_merge
//
// Takes one item per clock: a tick time plus SAMPLES 12-bit readings per axis,
// and returns zero or one result item (contact, touch_x, touch_y). Two lanes,
// one per axis, rank the readings in parallel and average the two middle
// ones, flagging a spread wider than spread_limit; their output is registered.
// The merge stage then checks the tick gap since the last pen-down, the edge
// margin and the jump from the previous sample, updates the stored state and
// loads the output register. Sustained rate is one item per cycle unless
// stalled. The feedback through the previous-sample and last-pen-down registers
// in the merge stage sets that rate. An item whose gap is too short, or whose
// pair jumped too far while clear of the edge, gives no result. The output
// register frees the input side, so a new item is taken while a finished
// result still waits if the lane stage is empty. Register writes are always
// ready and take effect on the next cycle; write them only while idle.
module touch_sample_filter_top import tsf_pkg::*; #(
  parameter int SAMPLES = TSF_SAMPLES
) (
  input  logic     clk,
  input  logic     rst_n,
  tsf_in_if.sink   in_ch,
  tsf_out_if.source out_ch,
  tsf_cfg_if.sink  cfg_ch
);

  // configuration registers
  tsf_cfg_t cfg_r, cfg_nxt;

  // lane stage register
  logic              s1_valid_r, s1_valid_nxt;
  logic [TICK_W-1:0] s1_now_r;
  tsf_axis_t         s1_x_r, s1_y_r;

  // output register
  logic        out_valid_r, out_valid_nxt;
  tsf_result_t out_r;

  tsf_axis_t   lane_x, lane_y;
  tsf_result_t merge_res;
  logic        out_free;
  logic        fire;
  logic        load;

  // one lane per axis
  tsf_lane #(.SAMPLES(SAMPLES)) u_lane_x (
    .samples      (in_ch.x_sample),
    .spread_limit (cfg_r.spread_limit),
    .axis         (lane_x)
  );

  tsf_lane #(.SAMPLES(SAMPLES)) u_lane_y (
    .samples      (in_ch.y_sample),
    .spread_limit (cfg_r.spread_limit),
    .axis         (lane_y)
  );

  // merge stage holds prev sample and last pen-down time
  tsf_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .now_ticks (s1_now_r),
    .x_axis    (s1_x_r),
    .y_axis    (s1_y_r),
    .cfg       (cfg_r),
    .res       (merge_res)
  );

  // handshake: output slot free when empty or being taken
  assign out_free     = !out_valid_r || out_ch.ready;
  assign fire         = s1_valid_r && out_free;
  assign in_ch.ready  = !s1_valid_r || out_free;
  assign load         = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid   = out_valid_r;
  assign out_ch.contact = out_r.contact;
  assign out_ch.touch_x = out_r.touch_x;
  assign out_ch.touch_y = out_r.touch_y;

  // register writes, unknown indexes ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (tsf_cfg_idx_t'(cfg_ch.index))
        CFG_MIN_GAP: cfg_nxt.min_gap      = cfg_ch.data[GAP_W-1:0];
        CFG_SPREAD:  cfg_nxt.spread_limit = cfg_ch.data[ADC_W-1:0];
        CFG_JUMP:    cfg_nxt.jump_limit   = cfg_ch.data[ADC_W-1:0];
        CFG_MARGIN:  cfg_nxt.edge_margin  = cfg_ch.data[MARGIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // stage valids
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = merge_res.emit;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_gap      <= MIN_GAP_RESET;
      cfg_r.spread_limit <= SPREAD_RESET;
      cfg_r.jump_limit   <= JUMP_RESET;
      cfg_r.edge_margin  <= EDGE_MARGIN_RESET;
      s1_valid_r         <= 1'b0;
      out_valid_r        <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      s1_now_r <= in_ch.now_ticks;
      s1_x_r   <= lane_x;
      s1_y_r   <= lane_y;
    end
    if (fire) begin
      out_r <= merge_res;
    end
  end

endmodule

### hdl/tsf_checker.sv
// tsf_checker: port-level assertions for touch_sample_filter_top and its bind
// depends on tsf_pkg and touch_sample_filter_top_macros.svh
`include "touch_sample_filter_top_macros.svh"

module tsf_checker import tsf_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_contact,
  input logic [ADC_W-1:0] out_touch_x,
  input logic [ADC_W-1:0] out_touch_y
);

  // a stalled result stays offered
  `TSF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid,
                   "result dropped while stalled")

  // pen-up carries zero coordinates
  `TSF_ASSERT_IMPLY(a_penup_zero, clk, rst_n, out_valid && !out_contact,
                    (out_touch_x == '0) && (out_touch_y == '0),
                    "pen-up with nonzero coordinates")

  // nothing offered right after reset
  `TSF_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid, "result offered after reset")

  // a fresh result comes from an item taken through the lane stage and output registers
  `TSF_ASSERT_IMPLY(a_latency, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 2),
                    "result without a matching item")

endmodule

bind touch_sample_filter_top tsf_checker u_tsf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_contact (out_ch.contact),
  .out_touch_x (out_ch.touch_x),
  .out_touch_y (out_ch.touch_y)
);

### dv/touch_sample_filter_top_tb.sv
// touch_sample_filter_top_tb: self-checking testbench for the touch sample filter,
// with its own filter model, random strokes and register sweeps
// depends on tsf_pkg, tsf_channels and touch_sample_filter_top
module touch_sample_filter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tsf_pkg::*;

  localparam int SAMPLES       = TSF_SAMPLES;
  localparam int ADC_LIMIT     = 4095;
  localparam int DRAIN_LIMIT   = 2000;  // cycles allowed for pending results to come
  localparam int SETTLE_CYCLES = 6;     // slack for the pipe to empty after the last report
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS   = 90;    // live items per random phase

  // index that maps to no register, writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'hA5;

  typedef logic [SAMPLES*ADC_W-1:0] axis_readings_t;

  typedef struct packed {
    logic [TICK_W-1:0] now_ticks;
    axis_readings_t    x_sample;
    axis_readings_t    y_sample;
  } sample_item_t;

  typedef struct packed {
    logic             contact;
    logic [ADC_W-1:0] touch_x;
    logic [ADC_W-1:0] touch_y;
  } touch_report_t;

  logic clk;
  logic rst_n;

  tsf_in_if #(.SAMPLES(SAMPLES)) in_ch ();
  tsf_out_if                     out_ch ();
  tsf_cfg_if                     cfg_ch ();

  touch_sample_filter_top #(.SAMPLES(SAMPLES)) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // filter model state: register copy, stored sample pair, time of last pen-down
  tsf_cfg_t          flt_cfg;
  logic [ADC_W-1:0]  held_x;
  logic [ADC_W-1:0]  held_y;
  logic [TICK_W-1:0] last_down_tick;

  touch_report_t pending_reports[$];  // reports still owed by the block, oldest first
  int            live_items;          // items that got past the gap check
  int            mismatch_count;
  bit            idle_bursts;         // random gaps on both sides while set
  int            ready_hold;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // filter model
  // ---------------------------------------------------------------------------

  // rank one axis descending and average the two middle readings,
  // flag the axis when the middle pair is spread too wide
  function automatic tsf_axis_t median_pair(input axis_readings_t raw);
    logic [ADC_W-1:0] v [SAMPLES];
    logic [ADC_W-1:0] t;
    logic [ADC_W:0]   sum;
    tsf_axis_t        r;
    for (int i = 0; i < SAMPLES; i++) v[i] = raw[i*ADC_W +: ADC_W];
    for (int i = 0; i < SAMPLES; i++) begin
      for (int j = i + 1; j < SAMPLES; j++) begin
        if (v[j] > v[i]) begin
          t    = v[j];
          v[j] = v[i];
          v[i] = t;
        end
      end
    end
    r.bad   = (v[SAMPLES/2-1] - v[SAMPLES/2]) > flt_cfg.spread_limit;
    sum     = v[SAMPLES/2-1] + v[SAMPLES/2];
    r.value = r.bad ? '0 : sum[ADC_W:1];
    return r;
  endfunction

  function automatic bit near_edge(input logic [ADC_W-1:0] v);
    return int'(v) <= int'(flt_cfg.edge_margin) ||
           int'(v) >= ADC_LIMIT - int'(flt_cfg.edge_margin);
  endfunction

  function automatic int axis_move(input logic [ADC_W-1:0] a, input logic [ADC_W-1:0] b);
    return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  // runs once per accepted item, queues the report it should cause
  function automatic void filter_touch_item(input sample_item_t it);
    logic [TICK_W-1:0] since;
    logic [ADC_W-1:0]  ox;
    logic [ADC_W-1:0]  oy;
    logic [ADC_W:0]    sum;
    tsf_axis_t         ax;
    tsf_axis_t         ay;
    touch_report_t     rep;
    since = it.now_ticks - last_down_tick;
    if (since <= flt_cfg.min_gap) return;
    live_items++;
    ox = held_x;
    oy = held_y;
    ax = median_pair(it.x_sample);
    ay = median_pair(it.y_sample);
    if (ax.bad || ay.bad) begin
      ax.value = '0;
      ay.value = '0;
    end
    held_x = ax.value;
    held_y = ay.value;
    if (near_edge(ax.value) || near_edge(ay.value)) begin
      rep = '0;
      pending_reports.push_back(rep);
      return;
    end
    if (axis_move(ox, ax.value) > int'(flt_cfg.jump_limit) ||
        axis_move(oy, ay.value) > int'(flt_cfg.jump_limit)) return;
    rep.contact  = 1'b1;
    sum          = ox + ax.value;
    rep.touch_x  = sum[ADC_W:1];
    sum          = oy + ay.value;
    rep.touch_y  = sum[ADC_W:1];
    last_down_tick = it.now_ticks;
    pending_reports.push_back(rep);
  endfunction

  // ---------------------------------------------------------------------------
  // drivers, all called at a falling edge and returning at one
  // ---------------------------------------------------------------------------

  // valid stays high on return, so back-to-back items need no gap;
  // wait_idle lowers it
  task automatic send_item(input sample_item_t it);
    if (idle_bursts && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.now_ticks <= it.now_ticks;
    in_ch.x_sample  <= it.x_sample;
    in_ch.y_sample  <= it.y_sample;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    filter_touch_item(it);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_MIN_GAP: flt_cfg.min_gap      = data[GAP_W-1:0];
      CFG_SPREAD:  flt_cfg.spread_limit = data[ADC_W-1:0];
      CFG_JUMP:    flt_cfg.jump_limit   = data[ADC_W-1:0];
      CFG_MARGIN:  flt_cfg.edge_margin  = data[MARGIN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] gap,
                            input logic [CFG_DATA_W-1:0] spread,
                            input logic [CFG_DATA_W-1:0] jump,
                            input logic [CFG_DATA_W-1:0] margin);
    write_reg(CFG_MIN_GAP, gap);
    write_reg(CFG_SPREAD, spread);
    write_reg(CFG_JUMP, jump);
    write_reg(CFG_MARGIN, margin);
    cfg_ch.valid <= 1'b0;
  endtask

  // stop sending, wait for every owed report, then let the pipe empty
  task automatic wait_idle();
    int guard;
    in_ch.valid <= 1'b0;
    guard = 0;
    while (pending_reports.size() != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    if (pending_reports.size() != 0) begin
      report_mismatch("reports never delivered", 0, pending_reports.size());
      pending_reports.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // item builders
  // ---------------------------------------------------------------------------

  function automatic axis_readings_t readings(input int a, input int b, input int c, input int d);
    int             src [4];
    axis_readings_t r;
    src = '{a, b, c, d};
    for (int i = 0; i < SAMPLES; i++) r[i*ADC_W +: ADC_W] = ADC_W'(src[i % 4]);
    return r;
  endfunction

  function automatic axis_readings_t even(input int v);
    return readings(v, v, v, v);
  endfunction

  function automatic sample_item_t pack_item(input logic [TICK_W-1:0] now,
                                             input axis_readings_t xs,
                                             input axis_readings_t ys);
    sample_item_t it;
    it.now_ticks = now;
    it.x_sample  = xs;
    it.y_sample  = ys;
    return it;
  endfunction

  // extra = 0 lands exactly on the minimum gap, which still counts as too short
  function automatic logic [TICK_W-1:0] tick_after(input int unsigned extra);
    return last_down_tick + flt_cfg.min_gap + extra;
  endfunction

  function automatic int clamp_adc(input int v);
    return (v < 0) ? 0 : (v > ADC_LIMIT) ? ADC_LIMIT : v;
  endfunction

  function automatic axis_readings_t jittered_axis(input int centre, input int width);
    axis_readings_t r;
    for (int i = 0; i < SAMPLES; i++)
      r[i*ADC_W +: ADC_W] =
        ADC_W'(clamp_adc(centre - width / 2 + int'($urandom_range(0, width))));
    return r;
  endfunction

  function automatic axis_readings_t noise_axis();
    axis_readings_t r;
    for (int i = 0; i < SAMPLES; i++) r[i*ADC_W +: ADC_W] = ADC_W'($urandom_range(0, ADC_LIMIT));
    return r;
  endfunction

  function automatic axis_readings_t edge_axis();
    int m;
    m = int'(flt_cfg.edge_margin);
    if ($urandom_range(0, 1)) return jittered_axis(int'($urandom_range(0, m)), 0);
    return jittered_axis(ADC_LIMIT - int'($urandom_range(0, m)), 0);
  endfunction

  // mostly past the gap, sometimes too short, exactly on it, or anywhere
  function automatic logic [TICK_W-1:0] pick_tick();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return last_down_tick + $urandom_range(0, flt_cfg.min_gap);
    if (r < 10) return tick_after(0);
    if (r < 14) return $urandom();
    return tick_after(1 + $urandom_range(0, 60));
  endfunction

  function automatic int pick_centre();
    int lo;
    int hi;
    lo = int'(flt_cfg.edge_margin) + 1;
    hi = ADC_LIMIT - int'(flt_cfg.edge_margin) - 1;
    if (lo > hi) return int'($urandom_range(0, ADC_LIMIT));
    return int'($urandom_range(lo, hi));
  endfunction

  // jitter mostly within the spread limit, now and then too wide
  function automatic int pick_width();
    int wmax;
    wmax = (flt_cfg.spread_limit > 300) ? 300 : int'(flt_cfg.spread_limit);
    if ($urandom_range(0, 19) == 0)
      return int'(flt_cfg.spread_limit) + 1 + int'($urandom_range(0, 300));
    return int'($urandom_range(0, wmax));
  endfunction

  // pen movement mostly within the jump limit, now and then a leap
  function automatic int pick_step();
    int jl;
    jl = (flt_cfg.jump_limit > 200) ? 200 : int'(flt_cfg.jump_limit);
    if ($urandom_range(0, 14) == 0)
      return ($urandom_range(0, 1) ? 1 : -1) * (jl + 1 + int'($urandom_range(0, 300)));
    return int'($urandom_range(0, 2 * jl)) - jl;
  endfunction

  // one pen stroke: a wandering point with noisy readings, then usually a lift
  task automatic send_stroke();
    int           len;
    int           cx;
    int           cy;
    int unsigned  r;
    sample_item_t it;
    len = $urandom_range(3, 30);
    cx  = pick_centre();
    cy  = pick_centre();
    for (int n = 0; n < len; n++) begin
      it = pack_item(pick_tick(), jittered_axis(cx, pick_width()),
                     jittered_axis(cy, pick_width()));
      send_item(it);
      cx = clamp_adc(cx + pick_step());
      cy = clamp_adc(cy + pick_step());
    end
    r = $urandom_range(0, 9);
    if (r < 3) begin
      send_item(pack_item(pick_tick(), edge_axis(), jittered_axis(pick_centre(), 0)));
    end else if (r < 6) begin
      send_item(pack_item(pick_tick(), jittered_axis(pick_centre(), 0), edge_axis()));
    end else if (r < 8) begin
      send_item(pack_item($urandom(), noise_axis(), noise_axis()));
    end
  endtask

  task automatic run_strokes(input int count);
    int target;
    target = live_items + count;
    while (live_items < target) send_stroke();
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked items against the reset register values
  task automatic test_directed_cases();
    idle_bursts = 1'b1;
    // gap equal to the minimum is ignored, then a first touch jumps from zero
    send_item(pack_item(tick_after(0), even(2000), even(1000)));
    send_item(pack_item(tick_after(1), even(2000), even(1000)));
    send_item(pack_item(tick_after(1), even(2010), even(1010)));
    // middle spread exactly at the limit, then one over on x, then on y
    send_item(pack_item(tick_after(1), readings(0, 2000, 2050, ADC_LIMIT), even(1020)));
    send_item(pack_item(tick_after(1), readings(2000, 2051, 2000, 2051), even(1020)));
    send_item(pack_item(tick_after(1), even(2000), readings(3000, 3051, ADC_LIMIT, 0)));
    // edge margin boundaries, low and high, each axis
    send_item(pack_item(tick_after(1), even(10), even(2000)));
    send_item(pack_item(tick_after(1), even(11), even(2000)));
    send_item(pack_item(tick_after(1), even(4085), even(2000)));
    send_item(pack_item(tick_after(1), even(4084), even(2000)));
    send_item(pack_item(tick_after(1), even(2000), even(10)));
    send_item(pack_item(tick_after(1), even(2000), even(11)));
    send_item(pack_item(tick_after(1), even(2000), even(4085)));
    send_item(pack_item(tick_after(1), even(2000), even(4084)));
    // jump exactly at the limit, then one over on x and on y
    send_item(pack_item(tick_after(1), even(2000), even(2000)));
    send_item(pack_item(tick_after(1), even(2050), even(2000)));
    send_item(pack_item(tick_after(1), even(2101), even(2000)));
    send_item(pack_item(tick_after(1), even(2101), even(1949)));
    // readings at full scale and a split that is as wide as it gets
    send_item(pack_item(tick_after(1), even(0), even(0)));
    send_item(pack_item(tick_after(1), even(ADC_LIMIT), even(ADC_LIMIT)));
    send_item(pack_item(tick_after(1), readings(0, 0, ADC_LIMIT, ADC_LIMIT), even(2000)));
    // tick counter wrapping between two pen-downs
    send_item(pack_item(32'hFFFF_FFF0, even(3000), even(3000)));
    send_item(pack_item(32'hFFFF_FFF8, even(3000), even(3000)));
    send_item(pack_item(32'h0000_000C, even(3001), even(3001)));
    send_item(pack_item(32'h0000_000D, even(3001), even(3001)));
    wait_idle();
  endtask

  // every register at both ends, plus a write to an index with no register
  task automatic test_register_extremes();
    idle_bursts = 1'b1;
    set_config('0, '0, '0, '0);
    run_strokes(30);
    wait_idle();
    set_config(16'hFFFF, 16'h0FFF, 16'h0FFF, 16'h07FF);
    run_strokes(30);
    wait_idle();
    set_config('0, 16'h0FFF, 16'h0FFF, '0);
    run_strokes(30);
    wait_idle();
    write_reg(CFG_UNUSED, 16'hFFFF);
    cfg_ch.valid <= 1'b0;
    run_strokes(20);
    wait_idle();
  endtask

  // random strokes under a run of register settings, the last one with no gaps
  task automatic test_random_strokes();
    logic [CFG_DATA_W-1:0] gap;
    logic [CFG_DATA_W-1:0] spread;
    logic [CFG_DATA_W-1:0] jump;
    logic [CFG_DATA_W-1:0] margin;
    int                    target;
    bit                    paused;
    paused = 1'b0;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        gap    = MIN_GAP_RESET;
        spread = SPREAD_RESET;
        jump   = JUMP_RESET;
        margin = EDGE_MARGIN_RESET;
      end else begin
        gap    = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 65535))
                                             : CFG_DATA_W'($urandom_range(0, 40));
        spread = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 4095))
                                             : CFG_DATA_W'($urandom_range(0, 120));
        jump   = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 4095))
                                             : CFG_DATA_W'($urandom_range(0, 120));
        margin = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 2047))
                                             : CFG_DATA_W'($urandom_range(0, 60));
      end
      // bits above a register's width must be dropped
      if (phase % 2 == 1) begin
        spread[CFG_DATA_W-1:ADC_W]    = (CFG_DATA_W-ADC_W)'($urandom());
        jump[CFG_DATA_W-1:ADC_W]      = (CFG_DATA_W-ADC_W)'($urandom());
        margin[CFG_DATA_W-1:MARGIN_W] = (CFG_DATA_W-MARGIN_W)'($urandom());
      end
      set_config(gap, spread, jump, margin);
      target = live_items + PHASE_ITEMS;
      while (live_items < target) begin
        idle_bursts = (phase < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
        send_stroke();
        // hold the sender once until every owed report is out
        if (phase == 3 && !paused && live_items > target - PHASE_ITEMS / 2) begin
          wait_idle();
          paused = 1'b1;
        end
      end
      wait_idle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // ready drops in random bursts while idle_bursts is set
  always @(negedge clk) begin
    if (ready_hold != 0) begin
      ready_hold--;
      out_ch.ready <= 1'b0;
    end else if (idle_bursts && $urandom_range(0, 5) == 0) begin
      ready_hold = $urandom_range(0, 8);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // each delivered result against the oldest owed report
  always @(posedge clk) begin : check_results
    touch_report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("result with none owed", out_ch.contact, 0);
      end else begin
        want = pending_reports.pop_front();
        if (out_ch.contact !== want.contact)
          report_mismatch("contact", out_ch.contact, want.contact);
        if (out_ch.touch_x !== want.touch_x)
          report_mismatch("touch_x", out_ch.touch_x, want.touch_x);
        if (out_ch.touch_y !== want.touch_y)
          report_mismatch("touch_y", out_ch.touch_y, want.touch_y);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    // every input known from time zero
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.now_ticks = '0;
    in_ch.x_sample  = '0;
    in_ch.y_sample  = '0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    idle_bursts     = 1'b0;
    ready_hold      = 0;
    live_items      = 0;
    mismatch_count  = 0;

    // model starts from the reset state
    flt_cfg.min_gap      = MIN_GAP_RESET;
    flt_cfg.spread_limit = SPREAD_RESET;
    flt_cfg.jump_limit   = JUMP_RESET;
    flt_cfg.edge_margin  = EDGE_MARGIN_RESET;
    held_x               = '0;
    held_y               = '0;
    last_down_tick       = '0;

    // synchronous reset, released on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_register_extremes();
    test_random_strokes();
    wait_idle();

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
